[rtl/mbtb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mbtb_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int X_W       = $clog2(MAX_WIDTH);
    localparam int EW_W      = X_W + 1;
    localparam int ROW_W     = 16;
    localparam int PIX_W     = 24;
    localparam int LINE_W    = 8 + 8 + PIX_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 16;
    localparam int IN_DW     = 32;
    localparam int OUT_DW    = 56;

    localparam logic [CFG_AW-1:0] REG_TINT_RED     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_TINT_GREEN   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_TINT_BLUE    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd4;

    localparam logic [7:0]  TINT_RESET   = 8'd220;
    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    // floor(v / 765) == (v * RECIP_K) >> RECIP_SH for v < 2^18
    localparam logic [18:0] RECIP_K  = 19'd350897;
    localparam int          RECIP_SH = 28;
    localparam logic [9:0]  FULL_W   = 10'd765;

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [ROW_W-1:0] r;
        logic [7:0]       h;
        logic [PIX_W-1:0] pix;
        logic             last_row;
        logic             bypass;
        logic             last;
    } job_t;

    function automatic logic [17:0] mix_sum(input logic [7:0] d, input logic [7:0] t,
                                            input logic [7:0] w);
        logic [9:0] inv;
        inv = FULL_W - {2'b0, w};
        return ({10'b0, d} * {8'b0, inv}) + ({10'b0, t} * {10'b0, w});
    endfunction

endpackage
`default_nettype wire

[rtl/mask_blur_tint_blend_core.sv]
// Mask blur, tint and blend core.
// Input stream s_*: one pixel per request in raster order, mask bit and BGR pixel.
// Output stream m_*: blended pixels with column and row; m_tlast marks the last
// result caused by one input request (up to four results per input).
// Config port: cfg_we writes cfg_wdata into register cfg_addr (tints, width,
// height); write only while the core is idle.
// A pixel normally comes out one row after it went in; on the last row the
// previous row and the current row are both emitted. With width or height of
// 2 or less, each pixel comes out right away, unblurred.
// A result passes the job queue, the line store read and three blend stages
// (p1, p2, out) before m_tvalid rises.
// Throughput: one input per cycle on inner rows while the job queue is not full;
// the last pixel of a row makes two jobs and s_tready drops while the second
// waits. On the last row each job emits two results, bounded by the single blend path.
// Reset clears counters, queue and output; line stores are not cleared. The
// first row after reset writes them before any stored value is used.
// When m_tvalid is high and m_tready low, the output holds and the pipeline
// stalls; the input side keeps accepting until the four-entry job queue fills.
`timescale 1ns / 1ps
`default_nettype none
module mask_blur_tint_blend_core
    import mbtb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,   // mask_on, dst_blue, dst_green, dst_red
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_DW-1:0]      m_tdata,   // out_col, out_row, out_blue, out_green, out_red
    output logic                   m_tlast,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_wdata
);
    logic [7:0]  tint_red_reg, tint_green_reg, tint_blue_reg;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic        q_full, q_push, q_empty, q_pop;
    job_t        q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_red_reg   <= TINT_RESET;
            tint_green_reg <= TINT_RESET;
            tint_blue_reg  <= TINT_RESET;
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TINT_RED:     tint_red_reg   <= cfg_wdata[7:0];
                REG_TINT_GREEN:   tint_green_reg <= cfg_wdata[7:0];
                REG_TINT_BLUE:    tint_blue_reg  <= cfg_wdata[7:0];
                REG_IMAGE_WIDTH:  width_reg      <= cfg_wdata[12:0];
                REG_IMAGE_HEIGHT: height_reg     <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    mbtb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .image_width (width_reg),
        .image_height(height_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    mbtb_fifo u_fifo (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(q_wdata),
        .full (q_full),
        .pop  (q_pop),
        .empty(q_empty),
        .rdata(q_rdata)
    );

    mbtb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .tint_red  (tint_red_reg),
        .tint_green(tint_green_reg),
        .tint_blue (tint_blue_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );
endmodule
`default_nettype wire

[rtl/mbtb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module mbtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/mbtb_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module mbtb_fifo
    import mbtb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t wdata,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output job_t      rdata
);
    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end
endmodule
`default_nettype wire

[rtl/mbtb_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module mbtb_front
    import mbtb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,
    input  wire logic [12:0]       image_width,
    input  wire logic [15:0]       image_height,
    input  wire logic              q_full,
    output logic                   q_push,
    output job_t                   q_wdata
);
    logic [X_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [1:0]       mw_reg, mw_next;
    logic [PIX_W-1:0] hold_reg;
    logic             pend_reg, pend_next;
    job_t             pend_job_reg;

    logic [EW_W-1:0]  ew;
    logic [X_W-1:0]   ew_m1, c;
    logic [ROW_W-1:0] eh_m1, r;
    logic             last_col, last_row, bypass, accept, bit_in;
    logic             has_a, has_b;
    logic [PIX_W-1:0] pix;
    logic [9:0]       sum_a, sum_b;
    job_t             ja, jb;

    always_comb
    begin
        if (image_width == '0)
        begin
            ew = EW_W'(1);
        end
        else if (image_width > 13'(MAX_WIDTH))
        begin
            ew = EW_W'(MAX_WIDTH);
        end
        else
        begin
            ew = image_width[EW_W-1:0];
        end
        ew_m1 = X_W'(ew - EW_W'(1));
        eh_m1 = (image_height == '0) ? '0 : image_height - 16'd1;
        c = (col_reg > ew_m1) ? ew_m1 : col_reg;
        r = (row_reg > eh_m1) ? eh_m1 : row_reg;
        last_col = (c == ew_m1);
        last_row = (r == eh_m1);
        bypass   = (ew <= EW_W'(2)) || (eh_m1 <= 16'd1);
        bit_in   = s_tdata[0];
        pix      = s_tdata[PIX_W:1];

        sum_a = ((c >= X_W'(2) && mw_reg[1]) ? 10'd255 : 10'd0)
              + (mw_reg[0] ? 10'd510 : 10'd0) + (bit_in ? 10'd255 : 10'd0);
        sum_b = ((c != '0 && mw_reg[0]) ? 10'd255 : 10'd0) + (bit_in ? 10'd510 : 10'd0);

        has_a = !bypass && (c != '0);
        has_b = !bypass && last_col;

        ja.x = c - X_W'(1);
        ja.r = r;
        ja.h = sum_a[9:2];
        ja.pix = hold_reg;
        ja.last_row = last_row;
        ja.bypass = 1'b0;
        ja.last = !has_b;

        jb.x = c;
        jb.r = r;
        jb.h = bypass ? {8{bit_in}} : sum_b[9:2];
        jb.pix = pix;
        jb.last_row = last_row;
        jb.bypass = bypass;
        jb.last = 1'b1;
    end

    assign s_tready = !pend_reg && !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        q_push  = 1'b0;
        q_wdata = jb;
        pend_next = pend_reg;
        col_next = col_reg;
        row_next = row_reg;
        mw_next  = mw_reg;
        if (pend_reg)
        begin
            q_wdata = pend_job_reg;
            q_push  = !q_full;
            pend_next = q_full;
        end
        else if (accept)
        begin
            q_push  = bypass || has_a || has_b;
            q_wdata = has_a ? ja : jb;
            pend_next = has_a && has_b;
            mw_next = {mw_reg[0], bit_in};
            if (last_col)
            begin
                col_next = '0;
                mw_next  = '0;
                row_next = last_row ? '0 : r + 16'd1;
            end
            else
            begin
                col_next = c + X_W'(1);
                row_next = r;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg     <= pix;
            pend_job_reg <= jb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            mw_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            mw_reg   <= mw_next;
            pend_reg <= pend_next;
        end
    end
endmodule
`default_nettype wire

[rtl/mbtb_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module mbtb_back
    import mbtb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire job_t              q_rdata,
    output logic                   q_pop,
    input  wire logic [7:0]        tint_red,
    input  wire logic [7:0]        tint_green,
    input  wire logic [7:0]        tint_blue,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_DW-1:0]      m_tdata,
    output logic                   m_tlast
);
    job_t             s1_reg;
    logic             s1_valid_reg, phase_reg;
    logic [LINE_W-1:0] rd;
    logic             en, need_prev, need_cur, emit_v, emit_prev, retire, e_last;
    logic [7:0]       older, prev, w_prev, w_cur, e_w;
    logic [PIX_W-1:0] dprev, e_pix;
    logic [ROW_W-1:0] e_row;
    logic [9:0]       s_prev, s_cur;

    logic             p1_v_reg, p2_v_reg, out_v_reg;
    logic [X_W-1:0]   p1_col_reg, p2_col_reg, out_col_reg;
    logic [ROW_W-1:0] p1_row_reg, p2_row_reg, out_row_reg;
    logic             p1_last_reg, p2_last_reg, out_last_reg;
    logic [17:0]      p1_sum_reg [3];
    logic [36:0]      p2_q_reg [3];
    logic [7:0]       out_ch_reg [3];
    logic [7:0]       tint [3];

    assign en = !out_v_reg || m_tready;

    always_comb
    begin
        older = rd[7:0];
        prev  = rd[15:8];
        dprev = rd[LINE_W-1:16];
        s_prev = ((s1_reg.r >= 16'd2) ? {2'b0, older} : 10'd0) + {1'b0, prev, 1'b0}
               + {2'b0, s1_reg.h};
        s_cur  = ((s1_reg.r != '0) ? {2'b0, prev} : 10'd0) + {1'b0, s1_reg.h, 1'b0};
        w_prev = s_prev[9:2];
        w_cur  = s1_reg.bypass ? s1_reg.h : s_cur[9:2];
        need_prev = !s1_reg.bypass && (s1_reg.r != '0);
        need_cur  = s1_reg.bypass || s1_reg.last_row;
        emit_prev = !phase_reg && need_prev;
        emit_v = s1_valid_reg && (phase_reg || need_prev || need_cur);
        e_w    = emit_prev ? w_prev : w_cur;
        e_pix  = emit_prev ? dprev : s1_reg.pix;
        e_row  = emit_prev ? s1_reg.r - 16'd1 : s1_reg.r;
        e_last = s1_reg.last && !(emit_prev && need_cur);
        retire = s1_valid_reg && en && (phase_reg || !(need_prev && need_cur));
        q_pop  = !q_empty && (!s1_valid_reg || retire);
    end

    mbtb_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .clk  (clk),
        .we   (retire && !s1_reg.bypass),
        .waddr(s1_reg.x),
        .wdata({s1_reg.pix, s1_reg.h, prev}),
        .re   (q_pop),
        .raddr(q_rdata.x),
        .rdata(rd)
    );

    assign tint[0] = tint_blue;
    assign tint[1] = tint_green;
    assign tint[2] = tint_red;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg <= q_rdata;
        end
        if (en)
        begin
            p1_col_reg  <= s1_reg.x;
            p1_row_reg  <= e_row;
            p1_last_reg <= e_last;
            p2_col_reg  <= p1_col_reg;
            p2_row_reg  <= p1_row_reg;
            p2_last_reg <= p1_last_reg;
            out_col_reg  <= p2_col_reg;
            out_row_reg  <= p2_row_reg;
            out_last_reg <= p2_last_reg;
            for (int i = 0; i < 3; i++)
            begin
                p1_sum_reg[i] <= mix_sum(e_pix[8*i +: 8], tint[i], e_w);
                p2_q_reg[i]   <= {19'b0, p1_sum_reg[i]} * {18'b0, RECIP_K};
                out_ch_reg[i] <= p2_q_reg[i][RECIP_SH +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
                phase_reg    <= 1'b0;
            end
            else if (retire)
            begin
                s1_valid_reg <= 1'b0;
            end
            else if (s1_valid_reg && en)
            begin
                phase_reg <= 1'b1;
            end
            if (en)
            begin
                p1_v_reg  <= emit_v;
                p2_v_reg  <= p1_v_reg;
                out_v_reg <= p2_v_reg;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_ch_reg[2], out_ch_reg[1], out_ch_reg[0],
                       out_row_reg, out_col_reg};
endmodule
`default_nettype wire

[rtl/mbtb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module mbtb_checker
    import mbtb_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_DW-1:0] m_tdata,
    input wire logic              m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tlast))
        else $error("output dropped while stalled");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_DW-1:52] == '0)
        else $error("tdata padding not zero");

    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");
endmodule

bind mask_blur_tint_blend_core mbtb_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
`default_nettype wire
